// File: src/sws_pkg.sv
// ----------------------------------------------------------------------------
// Sensor window statistics package
// Shared widths, codes and reset values of the window statistics block.
// ----------------------------------------------------------------------------
package sws_pkg;

    localparam int MAX_CLIMATE = 16;
    localparam int MAX_MOTION  = 256;

    localparam int CCNT_W = 5;
    localparam int MCNT_W = 9;
    localparam int STAT_W = 18;
    localparam int CFG_W  = 16;
    localparam int CIDX_W = 3;
    localparam int DIVN_W = 25;
    localparam int DIVD_W = 9;
    localparam int ROOT_W = 16;
    localparam int RAD_W  = 32;

    typedef enum logic [1:0] {
        KIND_CLIMATE = 2'd0,
        KIND_MOTION  = 2'd1,
        KIND_CLOSE   = 2'd2,
        KIND_NONE    = 2'd3
    } t_kind;

    typedef enum logic [CIDX_W-1:0] {
        CFG_TEMP_HIGH  = 3'd0,
        CFG_TEMP_LOW   = 3'd1,
        CFG_HUMID_HIGH = 3'd2,
        CFG_ACCEL_LIM  = 3'd3,
        CFG_GYRO_LIM   = 3'd4,
        CFG_VIB_SHARE  = 3'd5,
        CFG_MOT_SHARE  = 3'd6,
        CFG_UNUSED     = 3'd7
    } t_cfg_index;

    typedef enum logic [4:0] {
        STAT_CLIMATE_CNT = 5'd0,
        STAT_MOTION_CNT  = 5'd1,
        STAT_TEMP_MEAN   = 5'd2,
        STAT_HUMID_MEAN  = 5'd3,
        STAT_ACCEL_MEAN  = 5'd4,
        STAT_GYRO_MEAN   = 5'd5,
        STAT_BOARD_MEAN  = 5'd6,
        STAT_TEMP_MIN    = 5'd7,
        STAT_HUMID_MIN   = 5'd8,
        STAT_TEMP_MAX    = 5'd9,
        STAT_HUMID_MAX   = 5'd10,
        STAT_ACCEL_PEAK  = 5'd11,
        STAT_GYRO_PEAK   = 5'd12,
        STAT_TEMP_ALERT  = 5'd13,
        STAT_HUMID_ALERT = 5'd14,
        STAT_VIB_FLAG    = 5'd15,
        STAT_MOT_FLAG    = 5'd16,
        STAT_ANY_ALERT   = 5'd17
    } t_stat_code;

    localparam logic signed [10:0] RST_TEMP_HIGH  = 11'sd350;
    localparam logic signed [10:0] RST_TEMP_LOW   = 11'sd100;
    localparam logic [9:0]         RST_HUMID_HIGH = 10'd800;
    localparam logic [15:0]        RST_ACCEL_LIM  = 16'd32768;
    localparam logic [15:0]        RST_GYRO_LIM   = 16'd13100;
    localparam logic [8:0]         RST_VIB_SHARE  = 9'd51;
    localparam logic [8:0]         RST_MOT_SHARE  = 9'd26;

endpackage

// File: src/sws_sample_if.sv
// ----------------------------------------------------------------------------
// Sample channel
// Valid/ready channel that carries one sensor sample or a close command.
// ----------------------------------------------------------------------------
interface sws_sample_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic signed [10:0] temperature;
    logic [9:0]         humidity;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
    logic signed [15:0] board_temp;

    modport source (output valid, kind, temperature, humidity, accel_x, accel_y, accel_z,
                    gyro_x, gyro_y, gyro_z, board_temp, input ready);
    modport sink (input valid, kind, temperature, humidity, accel_x, accel_y, accel_z,
                  gyro_x, gyro_y, gyro_z, board_temp, output ready);
endinterface

// File: src/sws_stat_if.sv
// ----------------------------------------------------------------------------
// Statistic channel
// Valid/ready channel that carries one window statistic.
// ----------------------------------------------------------------------------
interface sws_stat_if;
    logic               valid;
    logic               ready;
    logic [31:0]        window_number;
    logic [4:0]         stat_code;
    logic signed [17:0] stat_value;
    logic               last;

    modport source (output valid, window_number, stat_code, stat_value, last, input ready);
    modport sink (input valid, window_number, stat_code, stat_value, last, output ready);
endinterface

// File: src/sws_sqrt.sv
// ----------------------------------------------------------------------------
// Iterative square root
// Floor square root of a 32-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module sws_sqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [sws_pkg::RAD_W-1:0]     i_value,
    output logic                          o_done,
    output logic [sws_pkg::ROOT_W-1:0]    o_root
);
    logic                        r_busy;
    logic                        r_done;
    logic [sws_pkg::RAD_W-1:0]   r_v;
    logic [sws_pkg::RAD_W-1:0]   r_r;
    logic [sws_pkg::RAD_W-1:0]   r_bit;
    logic [sws_pkg::RAD_W:0]     w_trial;

    assign w_trial = {1'b0, r_r} + {1'b0, r_bit};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_bit == sws_pkg::RAD_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= i_value;
            r_r   <= '0;
            r_bit <= sws_pkg::RAD_W'(1) << (sws_pkg::RAD_W - 2);
        end else if (r_busy) begin
            if ({1'b0, r_v} >= w_trial) begin
                r_v <= r_v - w_trial[sws_pkg::RAD_W-1:0];
                r_r <= (r_r >> 1) + r_bit;
            end else begin
                r_r <= r_r >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_r[sws_pkg::ROOT_W-1:0];
endmodule

// File: src/sws_div.sv
// ----------------------------------------------------------------------------
// Iterative divider
// Unsigned restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sws_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [sws_pkg::DIVN_W-1:0]    i_dividend,
    input  logic [sws_pkg::DIVD_W-1:0]    i_divisor,
    output logic                          o_done,
    output logic [sws_pkg::DIVN_W-1:0]    o_quotient
);
    logic                        r_busy;
    logic                        r_done;
    logic [4:0]                  r_cnt;
    logic [sws_pkg::DIVD_W-1:0]  r_den;
    logic [sws_pkg::DIVD_W-1:0]  r_rem;
    logic [sws_pkg::DIVN_W-1:0]  r_quo;
    logic [sws_pkg::DIVD_W:0]    w_trial;
    logic                        w_ge;

    assign w_trial = {r_rem, r_quo[sws_pkg::DIVN_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'(sws_pkg::DIVN_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_divisor;
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= w_ge ? sws_pkg::DIVD_W'(w_trial - {1'b0, r_den})
                          : w_trial[sws_pkg::DIVD_W-1:0];
            r_quo <= {r_quo[sws_pkg::DIVN_W-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule

// File: src/sensor_window_statistics_core.sv
// ----------------------------------------------------------------------------
// Sensor window statistics core
// Windowed sums, extremes, magnitudes and alerts over climate and motion data.
// ----------------------------------------------------------------------------
// Samples and close commands enter on i_sample; statistics leave on o_stat.
// A climate sample is absorbed in the cycle it is accepted. A motion sample
// holds the input until its magnitudes are done: six squares through one
// multiplier and two square roots of 16 steps each on the shared root unit.
// A close command runs five mean divisions on the shared divider, then
// presents 18 statistics, one per cycle while o_stat is ready; the last one
// carries last. The input is ready only while the sequencer is idle. The
// final statistic may still wait in the output register while the next
// transaction is accepted. A stall on o_stat holds the sequencer in its
// output phase. Configuration writes land at any time through i_cfg_we,
// i_cfg_index and i_cfg_data. Reset restores the register defaults, clears
// the window and sets the window number to zero; there is no clearing pass.
// An empty close and kind 3 produce no output.
// ----------------------------------------------------------------------------
module sensor_window_statistics_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [sws_pkg::CIDX_W-1:0]        i_cfg_index,
    input  logic [sws_pkg::CFG_W-1:0]         i_cfg_data,
    sws_sample_if.sink                        i_sample,
    sws_stat_if.source                        o_stat
);
    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_MAG_SQ   = 6'b000010,
        ST_MAG_RT   = 6'b000100,
        ST_DIV_GO   = 6'b001000,
        ST_DIV_WAIT = 6'b010000,
        ST_EMIT     = 6'b100000
    } t_state;

    t_state r_state;

    logic signed [10:0] r_temp_high, r_temp_low;
    logic [9:0]         r_humid_high;
    logic [15:0]        r_accel_lim, r_gyro_lim;
    logic [8:0]         r_vib_share, r_mot_share;

    logic [31:0]                 r_win;
    logic [sws_pkg::CCNT_W-1:0]  r_ccnt;
    logic signed [15:0]          r_temp_sum;
    logic signed [10:0]          r_temp_min, r_temp_max;
    logic [13:0]                 r_humid_sum;
    logic [9:0]                  r_humid_min, r_humid_max;
    logic [sws_pkg::MCNT_W-1:0]  r_mcnt;
    logic [24:0]                 r_accel_sum, r_gyro_sum;
    logic [16:0]                 r_accel_peak, r_gyro_peak;
    logic signed [23:0]          r_board_sum;
    logic [8:0]                  r_accel_spk, r_gyro_spk;

    logic signed [15:0]          r_axis [6];
    logic signed [15:0]          r_board;
    logic [2:0]                  r_idx;
    logic [sws_pkg::RAD_W-1:0]   r_acc;
    logic [sws_pkg::ROOT_W-1:0]  r_am;
    logic [2:0]                  r_didx;
    logic signed [17:0]          r_mean [5];
    logic [4:0]                  r_k;

    logic                        r_ov;
    logic [31:0]                 r_owin;
    logic [4:0]                  r_ocode;
    logic signed [17:0]          r_oval;
    logic                        r_olast;

    logic                        w_accept;
    logic signed [31:0]          w_sq;
    logic [sws_pkg::RAD_W-1:0]   w_acc_next;
    logic                        w_sq_start;
    logic                        w_rt_done;
    logic [sws_pkg::ROOT_W-1:0]  w_root;
    logic                        w_div_done;
    logic [sws_pkg::DIVN_W-1:0]  w_quo;
    logic [sws_pkg::DIVN_W-1:0]  w_dividend;
    logic [sws_pkg::DIVD_W-1:0]  w_divisor;
    logic                        w_neg;
    logic                        w_load;
    logic signed [17:0]          w_val;
    logic signed [17:0]          w_thi, w_tlo;
    logic [14:0]                 w_hthr;
    logic [17:0]                 w_vprod, w_mprod;
    logic signed [17:0]          w_talert;
    logic                        w_halert, w_vflag, w_mflag;
    logic signed [10:0]          w_t;
    logic signed [15:0]          w_b;

    assign i_sample.ready = (r_state == ST_IDLE);
    assign w_accept       = i_sample.valid && i_sample.ready;
    assign w_t            = i_sample.temperature;

    // Shared squaring multiplier.
    assign w_sq       = r_axis[r_idx] * r_axis[r_idx];
    assign w_acc_next = r_acc + sws_pkg::RAD_W'(unsigned'(w_sq));
    assign w_sq_start = (r_state == ST_MAG_SQ) && (r_idx == 3'd2 || r_idx == 3'd5);

    sws_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sq_start),
        .i_value (w_acc_next),
        .o_done  (w_rt_done),
        .o_root  (w_root)
    );

    always_comb begin
        w_neg      = 1'b0;
        w_dividend = '0;
        w_divisor  = sws_pkg::DIVD_W'(r_mcnt);
        case (r_didx)
            3'd0: begin
                w_neg      = r_temp_sum < 0;
                w_dividend = sws_pkg::DIVN_W'(w_neg ? 17'(-r_temp_sum) : 17'(r_temp_sum));
                w_divisor  = sws_pkg::DIVD_W'(r_ccnt);
            end
            3'd1: begin
                w_dividend = sws_pkg::DIVN_W'(r_humid_sum);
                w_divisor  = sws_pkg::DIVD_W'(r_ccnt);
            end
            3'd2: w_dividend = r_accel_sum;
            3'd3: w_dividend = r_gyro_sum;
            3'd4: begin
                w_neg      = r_board_sum < 0;
                w_dividend = w_neg ? sws_pkg::DIVN_W'(-25'(r_board_sum))
                                   : sws_pkg::DIVN_W'(25'(r_board_sum));
            end
            default: w_dividend = '0;
        endcase
    end

    sws_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == ST_DIV_GO),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    // Alert thresholds are exact products of limit and sample count.
    assign w_thi   = 18'(r_temp_high) * 18'(signed'({1'b0, r_ccnt}));
    assign w_tlo   = 18'(r_temp_low) * 18'(signed'({1'b0, r_ccnt}));
    assign w_hthr  = 15'(r_humid_high) * 15'(r_ccnt);
    assign w_vprod = 18'(r_mcnt) * 18'(r_vib_share);
    assign w_mprod = 18'(r_mcnt) * 18'(r_mot_share);

    always_comb begin
        w_talert = '0;
        if (r_ccnt != '0) begin
            if (18'(r_temp_sum) > w_thi) begin
                w_talert = 18'sd1;
            end else if (18'(r_temp_sum) < w_tlo) begin
                w_talert = -18'sd1;
            end
        end
    end
    assign w_halert = (r_ccnt != '0) && (15'(r_humid_sum) > w_hthr);
    assign w_vflag  = (r_mcnt != '0) && ({1'b0, r_accel_spk} > w_vprod[17:8]);
    assign w_mflag  = (r_mcnt != '0) && ({1'b0, r_gyro_spk} > w_mprod[17:8]);

    always_comb begin
        w_val = '0;
        case (sws_pkg::t_stat_code'(r_k))
            sws_pkg::STAT_CLIMATE_CNT: w_val = 18'(r_ccnt);
            sws_pkg::STAT_MOTION_CNT:  w_val = 18'(r_mcnt);
            sws_pkg::STAT_TEMP_MEAN:   w_val = (r_ccnt != '0) ? r_mean[0] : '0;
            sws_pkg::STAT_HUMID_MEAN:  w_val = (r_ccnt != '0) ? r_mean[1] : '0;
            sws_pkg::STAT_ACCEL_MEAN:  w_val = (r_mcnt != '0) ? r_mean[2] : '0;
            sws_pkg::STAT_GYRO_MEAN:   w_val = (r_mcnt != '0) ? r_mean[3] : '0;
            sws_pkg::STAT_BOARD_MEAN:  w_val = (r_mcnt != '0) ? r_mean[4] : '0;
            sws_pkg::STAT_TEMP_MIN:    w_val = 18'(r_temp_min);
            sws_pkg::STAT_HUMID_MIN:   w_val = 18'(r_humid_min);
            sws_pkg::STAT_TEMP_MAX:    w_val = 18'(r_temp_max);
            sws_pkg::STAT_HUMID_MAX:   w_val = 18'(r_humid_max);
            sws_pkg::STAT_ACCEL_PEAK:  w_val = 18'(r_accel_peak);
            sws_pkg::STAT_GYRO_PEAK:   w_val = 18'(r_gyro_peak);
            sws_pkg::STAT_TEMP_ALERT:  w_val = w_talert;
            sws_pkg::STAT_HUMID_ALERT: w_val = 18'(w_halert);
            sws_pkg::STAT_VIB_FLAG:    w_val = 18'(w_vflag);
            sws_pkg::STAT_MOT_FLAG:    w_val = 18'(w_mflag);
            sws_pkg::STAT_ANY_ALERT:
                w_val = 18'((w_talert != '0) || w_halert || w_vflag || w_mflag);
            default: w_val = '0;
        endcase
    end

    assign w_load = (r_state == ST_EMIT) && (!r_ov || o_stat.ready);
    assign w_b    = r_board;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_high  <= sws_pkg::RST_TEMP_HIGH;
            r_temp_low   <= sws_pkg::RST_TEMP_LOW;
            r_humid_high <= sws_pkg::RST_HUMID_HIGH;
            r_accel_lim  <= sws_pkg::RST_ACCEL_LIM;
            r_gyro_lim   <= sws_pkg::RST_GYRO_LIM;
            r_vib_share  <= sws_pkg::RST_VIB_SHARE;
            r_mot_share  <= sws_pkg::RST_MOT_SHARE;
        end else if (i_cfg_we) begin
            case (sws_pkg::t_cfg_index'(i_cfg_index))
                sws_pkg::CFG_TEMP_HIGH:  r_temp_high  <= i_cfg_data[10:0];
                sws_pkg::CFG_TEMP_LOW:   r_temp_low   <= i_cfg_data[10:0];
                sws_pkg::CFG_HUMID_HIGH: r_humid_high <= i_cfg_data[9:0];
                sws_pkg::CFG_ACCEL_LIM:  r_accel_lim  <= i_cfg_data;
                sws_pkg::CFG_GYRO_LIM:   r_gyro_lim   <= i_cfg_data;
                sws_pkg::CFG_VIB_SHARE:  r_vib_share  <= i_cfg_data[8:0];
                sws_pkg::CFG_MOT_SHARE:  r_mot_share  <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_load && r_k == 5'(sws_pkg::STAT_ANY_ALERT))) begin
            r_ccnt       <= '0;
            r_temp_sum   <= '0;
            r_temp_min   <= '0;
            r_temp_max   <= '0;
            r_humid_sum  <= '0;
            r_humid_min  <= '0;
            r_humid_max  <= '0;
            r_mcnt       <= '0;
            r_accel_sum  <= '0;
            r_gyro_sum   <= '0;
            r_accel_peak <= '0;
            r_gyro_peak  <= '0;
            r_board_sum  <= '0;
            r_accel_spk  <= '0;
            r_gyro_spk   <= '0;
        end else begin
            if (w_accept && i_sample.kind == sws_pkg::KIND_CLIMATE
                    && r_ccnt < sws_pkg::CCNT_W'(sws_pkg::MAX_CLIMATE)) begin
                if (r_ccnt == '0) begin
                    r_temp_min  <= w_t;
                    r_temp_max  <= w_t;
                    r_humid_min <= i_sample.humidity;
                    r_humid_max <= i_sample.humidity;
                end else begin
                    if (w_t < r_temp_min) r_temp_min <= w_t;
                    if (w_t > r_temp_max) r_temp_max <= w_t;
                    if (i_sample.humidity < r_humid_min) r_humid_min <= i_sample.humidity;
                    if (i_sample.humidity > r_humid_max) r_humid_max <= i_sample.humidity;
                end
                r_temp_sum  <= r_temp_sum + 16'(w_t);
                r_humid_sum <= r_humid_sum + 14'(i_sample.humidity);
                r_ccnt      <= r_ccnt + 1'b1;
            end
            if (r_state == ST_MAG_RT && w_rt_done && r_idx == 3'd6) begin
                r_accel_sum <= r_accel_sum + 25'(r_am);
                r_gyro_sum  <= r_gyro_sum + 25'(w_root);
                if (17'(r_am) > r_accel_peak) r_accel_peak <= 17'(r_am);
                if (17'(w_root) > r_gyro_peak) r_gyro_peak <= 17'(w_root);
                if (r_am > r_accel_lim) r_accel_spk <= r_accel_spk + 1'b1;
                if (w_root > r_gyro_lim) r_gyro_spk <= r_gyro_spk + 1'b1;
                r_board_sum <= r_board_sum + 24'(w_b);
                r_mcnt      <= r_mcnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
            r_didx  <= '0;
            r_k     <= '0;
            r_win   <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (w_load) begin
                r_ov <= 1'b1;
            end else if (o_stat.ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        if (i_sample.kind == sws_pkg::KIND_MOTION
                                && r_mcnt < sws_pkg::MCNT_W'(sws_pkg::MAX_MOTION)) begin
                            r_idx   <= '0;
                            r_state <= ST_MAG_SQ;
                        end else if (i_sample.kind == sws_pkg::KIND_CLOSE
                                && (r_ccnt != '0 || r_mcnt != '0)) begin
                            r_didx  <= '0;
                            r_state <= ST_DIV_GO;
                        end
                    end
                end
                ST_MAG_SQ: begin
                    r_idx <= r_idx + 3'd1;
                    if (w_sq_start) r_state <= ST_MAG_RT;
                end
                ST_MAG_RT: begin
                    if (w_rt_done) begin
                        r_state <= (r_idx == 3'd3) ? ST_MAG_SQ : ST_IDLE;
                    end
                end
                ST_DIV_GO: r_state <= ST_DIV_WAIT;
                ST_DIV_WAIT: begin
                    if (w_div_done) begin
                        r_didx <= r_didx + 3'd1;
                        if (r_didx == 3'd4) begin
                            r_k     <= '0;
                            r_state <= ST_EMIT;
                        end else begin
                            r_state <= ST_DIV_GO;
                        end
                    end
                end
                ST_EMIT: begin
                    if (w_load) begin
                        r_k  <= r_k + 5'd1;
                        if (r_k == 5'(sws_pkg::STAT_ANY_ALERT)) begin
                            r_win   <= r_win + 32'd1;
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_axis[0] <= i_sample.accel_x;
            r_axis[1] <= i_sample.accel_y;
            r_axis[2] <= i_sample.accel_z;
            r_axis[3] <= i_sample.gyro_x;
            r_axis[4] <= i_sample.gyro_y;
            r_axis[5] <= i_sample.gyro_z;
            r_board   <= i_sample.board_temp;
            r_acc     <= '0;
        end else if (r_state == ST_MAG_SQ) begin
            r_acc <= w_sq_start ? '0 : w_acc_next;
        end
        if (r_state == ST_MAG_RT && w_rt_done && r_idx == 3'd3) begin
            r_am <= w_root;
        end
        if (r_state == ST_DIV_WAIT && w_div_done) begin
            r_mean[r_didx] <= w_neg ? -18'(w_quo) : 18'(w_quo);
        end
        if (w_load) begin
            r_owin  <= r_win;
            r_ocode <= r_k;
            r_oval  <= w_val;
            r_olast <= (r_k == 5'(sws_pkg::STAT_ANY_ALERT));
        end
    end

    assign o_stat.valid         = r_ov;
    assign o_stat.window_number = r_owin;
    assign o_stat.stat_code     = r_ocode;
    assign o_stat.stat_value    = r_oval;
    assign o_stat.last          = r_olast;

    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("sequencer state is not one-hot");

    a_climate_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ccnt <= sws_pkg::CCNT_W'(sws_pkg::MAX_CLIMATE))
        else $error("climate count exceeds window capacity");

    a_last_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_stat.valid && o_stat.last) |-> o_stat.stat_code == 5'(sws_pkg::STAT_ANY_ALERT))
        else $error("last flag on a statistic other than the final one");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_stat.valid && !o_stat.ready && r_state == ST_EMIT) |=> $stable(r_k))
        else $error("statistic index advanced during an output stall");
endmodule

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// Sensor window statistics testbench
// Drives climate, motion and close transactions through bursts and gaps, and
// runs a stalling statistic receiver. A local window model predicts the 18
// statistics of every non-empty close. Each received statistic is compared
// field by field against the oldest prediction. The run covers several register
// settings, the extremes among them.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT  = 20000;
    localparam int SETTLE_CYC  = 300;
    localparam int PHASE_ITEMS = 20;

    typedef struct {
        sws_pkg::t_kind     kind;
        logic signed [10:0] temperature;
        logic [9:0]         humidity;
        logic signed [15:0] ax, ay, az, gx, gy, gz, board;
    } t_sample;

    typedef struct {
        logic [31:0]         window_number;
        sws_pkg::t_stat_code code;
        logic signed [17:0]  value;
        logic                last;
    } t_stat;

    typedef struct {
        t_sample             smp;
        bit                  chk;
        sws_pkg::t_stat_code chk_code;
        int                  chk_value;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [sws_pkg::CIDX_W-1:0] i_cfg_index = '0;
    logic [sws_pkg::CFG_W-1:0] i_cfg_data = '0;

    sws_sample_if sample_ch ();
    sws_stat_if stat_ch ();

    sensor_window_statistics_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_sample   (sample_ch.sink),
        .o_stat     (stat_ch.source)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Window model state and register copies.
    logic signed [10:0] lim_temp_high, lim_temp_low;
    logic [9:0]         lim_humid_high;
    logic [15:0]        lim_accel, lim_gyro;
    logic [8:0]         share_vib, share_mot;
    logic [31:0]        window_count;
    int                 n_climate, n_motion, n_accel_spikes, n_gyro_spikes;
    longint             temp_sum, temp_lo, temp_hi, humid_sum, humid_lo, humid_hi;
    longint             accel_sum, accel_peak, gyro_sum, gyro_peak, board_sum;

    t_stat pending_stats[$];
    int    errors = 0;
    int    mismatches = 0;
    int    burst_left = 0;
    int    rand_items = 0;
    int    idle_cycles = 0;
    int    stall_left = 0;
    int    rx_cycle = 0;
    bit    rx_stalling = 1'b0;

    function automatic longint floor_root(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        for (int i = 31; i >= 0; i--) begin
            b = r | (64'd1 << i);
            if (b * b <= v) begin
                r = b;
            end
        end
        return longint'(r);
    endfunction

    function automatic longint vec_mag(logic signed [15:0] x, logic signed [15:0] y,
                                       logic signed [15:0] z);
        longint unsigned acc;
        acc = longint'(x) * longint'(x) + longint'(y) * longint'(y)
            + longint'(z) * longint'(z);
        return floor_root(acc);
    endfunction

    function automatic void clear_window();
        n_climate = 0; n_motion = 0; n_accel_spikes = 0; n_gyro_spikes = 0;
        temp_sum = 0; temp_lo = 0; temp_hi = 0;
        humid_sum = 0; humid_lo = 0; humid_hi = 0;
        accel_sum = 0; accel_peak = 0; gyro_sum = 0; gyro_peak = 0; board_sum = 0;
    endfunction

    function automatic void reset_model();
        lim_temp_high = sws_pkg::RST_TEMP_HIGH; lim_temp_low = sws_pkg::RST_TEMP_LOW;
        lim_humid_high = sws_pkg::RST_HUMID_HIGH;
        lim_accel = sws_pkg::RST_ACCEL_LIM; lim_gyro = sws_pkg::RST_GYRO_LIM;
        share_vib = sws_pkg::RST_VIB_SHARE; share_mot = sws_pkg::RST_MOT_SHARE;
        window_count = '0;
        clear_window();
    endfunction

    function automatic void model_register(sws_pkg::t_cfg_index idx,
                                           logic [sws_pkg::CFG_W-1:0] data);
        case (idx)
            sws_pkg::CFG_TEMP_HIGH:  lim_temp_high = data[10:0];
            sws_pkg::CFG_TEMP_LOW:   lim_temp_low = data[10:0];
            sws_pkg::CFG_HUMID_HIGH: lim_humid_high = data[9:0];
            sws_pkg::CFG_ACCEL_LIM:  lim_accel = data;
            sws_pkg::CFG_GYRO_LIM:   lim_gyro = data;
            sws_pkg::CFG_VIB_SHARE:  share_vib = data[8:0];
            sws_pkg::CFG_MOT_SHARE:  share_mot = data[8:0];
            default: ;
        endcase
    endfunction

    // Returns the number of statistics queued by this transaction.
    function automatic int predict_window(t_sample s);
        longint st[18];
        longint am, gm, n;
        t_stat e;
        case (s.kind)
            sws_pkg::KIND_CLIMATE: begin
                if (n_climate >= sws_pkg::MAX_CLIMATE) return 0;
                if (n_climate == 0) begin
                    temp_lo = s.temperature; temp_hi = s.temperature;
                    humid_lo = s.humidity; humid_hi = s.humidity;
                end else begin
                    if (s.temperature < temp_lo) temp_lo = s.temperature;
                    if (s.temperature > temp_hi) temp_hi = s.temperature;
                    if (s.humidity < humid_lo) humid_lo = s.humidity;
                    if (s.humidity > humid_hi) humid_hi = s.humidity;
                end
                temp_sum += s.temperature;
                humid_sum += s.humidity;
                n_climate++;
                return 0;
            end
            sws_pkg::KIND_MOTION: begin
                if (n_motion >= sws_pkg::MAX_MOTION) return 0;
                am = vec_mag(s.ax, s.ay, s.az);
                gm = vec_mag(s.gx, s.gy, s.gz);
                accel_sum += am; gyro_sum += gm;
                if (am > accel_peak) accel_peak = am;
                if (gm > gyro_peak) gyro_peak = gm;
                if (am > longint'(lim_accel)) n_accel_spikes++;
                if (gm > longint'(lim_gyro)) n_gyro_spikes++;
                board_sum += s.board;
                n_motion++;
                return 0;
            end
            sws_pkg::KIND_CLOSE: begin
                if (n_climate == 0 && n_motion == 0) return 0;
                foreach (st[k]) st[k] = 0;
                st[sws_pkg::STAT_CLIMATE_CNT] = n_climate;
                st[sws_pkg::STAT_MOTION_CNT] = n_motion;
                if (n_climate > 0) begin
                    n = n_climate;
                    st[sws_pkg::STAT_TEMP_MEAN] = temp_sum / n;
                    st[sws_pkg::STAT_HUMID_MEAN] = humid_sum / n;
                    st[sws_pkg::STAT_TEMP_MIN] = temp_lo;
                    st[sws_pkg::STAT_HUMID_MIN] = humid_lo;
                    st[sws_pkg::STAT_TEMP_MAX] = temp_hi;
                    st[sws_pkg::STAT_HUMID_MAX] = humid_hi;
                    if (temp_sum > longint'(lim_temp_high) * n)
                        st[sws_pkg::STAT_TEMP_ALERT] = 1;
                    else if (temp_sum < longint'(lim_temp_low) * n)
                        st[sws_pkg::STAT_TEMP_ALERT] = -1;
                    st[sws_pkg::STAT_HUMID_ALERT] = (humid_sum > longint'(lim_humid_high) * n);
                end
                if (n_motion > 0) begin
                    n = n_motion;
                    st[sws_pkg::STAT_ACCEL_MEAN] = accel_sum / n;
                    st[sws_pkg::STAT_GYRO_MEAN] = gyro_sum / n;
                    st[sws_pkg::STAT_BOARD_MEAN] = board_sum / n;
                    st[sws_pkg::STAT_ACCEL_PEAK] = accel_peak;
                    st[sws_pkg::STAT_GYRO_PEAK] = gyro_peak;
                    st[sws_pkg::STAT_VIB_FLAG] = (n_accel_spikes > ((n * share_vib) >> 8));
                    st[sws_pkg::STAT_MOT_FLAG] = (n_gyro_spikes > ((n * share_mot) >> 8));
                end
                st[sws_pkg::STAT_ANY_ALERT] = (st[sws_pkg::STAT_TEMP_ALERT] != 0
                                            || st[sws_pkg::STAT_HUMID_ALERT] != 0
                                            || st[sws_pkg::STAT_VIB_FLAG] != 0
                                            || st[sws_pkg::STAT_MOT_FLAG] != 0);
                for (int k = 0; k < 18; k++) begin
                    e.window_number = window_count;
                    e.code = sws_pkg::t_stat_code'(k);
                    e.value = st[k][17:0];
                    e.last = (k == 17);
                    pending_stats.push_back(e);
                end
                window_count++;
                clear_window();
                return 18;
            end
            default: return 0;
        endcase
    endfunction

    function automatic void note_error(string what, longint exp_v, longint got_v);
        errors++;
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch %s: expected %0d, got %0d", what, exp_v, got_v);
        end
    endfunction

    // Statistic receiver with its own stall pattern.
    always @(posedge i_clk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 700 == 0) begin
            rx_stalling <= $urandom_range(0, 2) != 0;
        end
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            stat_ch.ready <= 1'b0;
        end else if (rx_stalling && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 25);
            stat_ch.ready <= 1'b0;
        end else begin
            stat_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_stat e;
        if (stat_ch.valid && stat_ch.ready) begin
            if (pending_stats.size() == 0) begin
                note_error("unexpected statistic code", -1, stat_ch.stat_code);
            end else begin
                e = pending_stats.pop_front();
                if (stat_ch.window_number !== e.window_number)
                    note_error("window_number", e.window_number, stat_ch.window_number);
                if (stat_ch.stat_code !== e.code)
                    note_error("stat_code", e.code, stat_ch.stat_code);
                if (stat_ch.stat_value !== e.value)
                    note_error($sformatf("stat_value of code %0d", e.code), e.value,
                               stat_ch.stat_value);
                if (stat_ch.last !== e.last)
                    note_error("last", e.last, stat_ch.last);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((sample_ch.valid && sample_ch.ready) || (stat_ch.valid && stat_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic write_register(sws_pkg::t_cfg_index idx, logic [sws_pkg::CFG_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        model_register(idx, data);
    endtask

    task automatic send_sample(t_sample s, output int produced);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0) begin
                sample_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        sample_ch.kind <= s.kind;
        sample_ch.temperature <= s.temperature;
        sample_ch.humidity <= s.humidity;
        sample_ch.accel_x <= s.ax;
        sample_ch.accel_y <= s.ay;
        sample_ch.accel_z <= s.az;
        sample_ch.gyro_x <= s.gx;
        sample_ch.gyro_y <= s.gy;
        sample_ch.gyro_z <= s.gz;
        sample_ch.board_temp <= s.board;
        sample_ch.valid <= 1'b1;
        do @(posedge i_clk); while (!sample_ch.ready);
        produced = predict_window(s);
    endtask

    task automatic drain_outputs();
        sample_ch.valid <= 1'b0;
        burst_left = 0;
        while (pending_stats.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    function automatic t_sample random_sample(sws_pkg::t_kind k);
        t_sample s;
        bit wide;
        wide = ($urandom_range(0, 7) == 0);
        s.kind = k;
        s.temperature = wide ? 11'($urandom) : 11'($signed($urandom_range(0, 1200)) - 400);
        s.humidity = wide ? 10'($urandom) : 10'($urandom_range(0, 1000));
        if ($urandom_range(0, 2) == 0) begin
            s.ax = 16'($signed($urandom_range(0, 4000)) - 2000);
            s.ay = 16'($signed($urandom_range(0, 4000)) - 2000);
            s.az = 16'($signed($urandom_range(0, 4000)) - 2000);
            s.gx = 16'($signed($urandom_range(0, 20000)) - 10000);
            s.gy = 16'($signed($urandom_range(0, 20000)) - 10000);
            s.gz = 16'($signed($urandom_range(0, 20000)) - 10000);
        end else begin
            s.ax = 16'($urandom); s.ay = 16'($urandom); s.az = 16'($urandom);
            s.gx = 16'($urandom); s.gy = 16'($urandom); s.gz = 16'($urandom);
        end
        s.board = 16'($urandom);
        return s;
    endfunction

    task automatic random_windows(int target, bit with_full_motion);
        int n_cl, n_mo, got;
        t_sample s;
        rand_items = 0;
        if (with_full_motion) begin
            for (int i = 0; i < sws_pkg::MAX_MOTION + 4; i++) begin
                send_sample(random_sample(sws_pkg::KIND_MOTION), got);
                rand_items++;
            end
            send_sample(random_sample(sws_pkg::KIND_CLOSE), got);
            rand_items++;
        end
        while (rand_items < target) begin
            if ($urandom_range(0, 9) == 0) begin
                s = random_sample($urandom_range(0, 1) ? sws_pkg::KIND_NONE
                                                       : sws_pkg::KIND_CLOSE);
                send_sample(s, got);
                rand_items++;
            end else begin
                n_cl = ($urandom_range(0, 5) == 0) ? $urandom_range(15, 20)
                                                   : $urandom_range(0, 5);
                n_mo = $urandom_range(0, 4);
                while (n_cl + n_mo > 0) begin
                    if (n_mo == 0 || (n_cl > 0 && $urandom_range(0, 1))) begin
                        s = random_sample(sws_pkg::KIND_CLIMATE);
                        n_cl--;
                    end else begin
                        s = random_sample(sws_pkg::KIND_MOTION);
                        n_mo--;
                    end
                    send_sample(s, got);
                    rand_items++;
                    if ($urandom_range(0, 15) == 0) begin
                        send_sample(random_sample(sws_pkg::KIND_NONE), got);
                        rand_items++;
                    end
                end
                send_sample(random_sample(sws_pkg::KIND_CLOSE), got);
                rand_items++;
            end
        end
    endtask

    t_row directed_rows[$];

    function automatic t_row mk(sws_pkg::t_kind k, int t, int h, int a, int g, int b,
                                bit chk = 0,
                                sws_pkg::t_stat_code c = sws_pkg::STAT_CLIMATE_CNT,
                                int v = 0);
        t_row r;
        r.smp.kind = k;
        r.smp.temperature = 11'(t);
        r.smp.humidity = 10'(h);
        r.smp.ax = 16'(a); r.smp.ay = 16'(a); r.smp.az = 16'(a);
        r.smp.gx = 16'(g); r.smp.gy = 16'(g); r.smp.gz = 16'(g);
        r.smp.board = 16'(b);
        r.chk = chk; r.chk_code = c; r.chk_value = v;
        return r;
    endfunction

    task automatic directed_part();
        int got;
        directed_rows = '{
            mk(sws_pkg::KIND_CLOSE, 0, 0, 0, 0, 0),
            mk(sws_pkg::KIND_NONE, 5, 5, 5, 5, 5),
            mk(sws_pkg::KIND_CLIMATE, 800, 1000, 0, 0, 0),
            mk(sws_pkg::KIND_CLIMATE, -400, 0, 0, 0, 0),
            mk(sws_pkg::KIND_MOTION, 0, 0, -32768, 32767, -32768),
            mk(sws_pkg::KIND_MOTION, 0, 0, 0, 0, 32767),
            mk(sws_pkg::KIND_CLOSE, 0, 0, 0, 0, 0, 1, sws_pkg::STAT_CLIMATE_CNT, 2),
            mk(sws_pkg::KIND_MOTION, 0, 0, 100, 0, 5),
            mk(sws_pkg::KIND_CLOSE, 0, 0, 0, 0, 0, 1, sws_pkg::STAT_TEMP_ALERT, 0),
            mk(sws_pkg::KIND_CLIMATE, 400, 900, 0, 0, 0),
            mk(sws_pkg::KIND_CLOSE, 0, 0, 0, 0, 0, 1, sws_pkg::STAT_TEMP_ALERT, 1),
            mk(sws_pkg::KIND_CLIMATE, 50, 0, 0, 0, 0),
            mk(sws_pkg::KIND_CLOSE, 0, 0, 0, 0, 0, 1, sws_pkg::STAT_TEMP_ALERT, -1),
            mk(sws_pkg::KIND_CLIMATE, 1023, 1023, 0, 0, 0),
            mk(sws_pkg::KIND_CLIMATE, -1024, 1001, 0, 0, 0),
            mk(sws_pkg::KIND_MOTION, 0, 0, 32767, -32768, -1),
            mk(sws_pkg::KIND_CLOSE, 0, 0, 0, 0, 0, 1, sws_pkg::STAT_ANY_ALERT, 1),
            mk(sws_pkg::KIND_NONE, 0, 0, 0, 0, 0),
            mk(sws_pkg::KIND_CLOSE, 0, 0, 0, 0, 0)
        };
        foreach (directed_rows[i]) begin
            send_sample(directed_rows[i].smp, got);
            if (directed_rows[i].chk && got == 18) begin
                if (pending_stats[pending_stats.size() - 18 + directed_rows[i].chk_code].value
                    != 18'(directed_rows[i].chk_value)) begin
                    note_error($sformatf("directed row %0d", i), directed_rows[i].chk_value,
                               pending_stats[pending_stats.size() - 18
                                             + directed_rows[i].chk_code].value);
                end
            end
        end
        for (int i = 0; i < sws_pkg::MAX_CLIMATE + 3; i++) begin
            send_sample(random_sample(sws_pkg::KIND_CLIMATE), got);
        end
        send_sample(random_sample(sws_pkg::KIND_CLOSE), got);
    endtask

    initial begin
        sample_ch.valid = 1'b0;
        sample_ch.kind = sws_pkg::KIND_NONE;
        sample_ch.temperature = '0;
        sample_ch.humidity = '0;
        sample_ch.accel_x = '0; sample_ch.accel_y = '0; sample_ch.accel_z = '0;
        sample_ch.gyro_x = '0; sample_ch.gyro_y = '0; sample_ch.gyro_z = '0;
        sample_ch.board_temp = '0;
        stat_ch.ready = 1'b0;
        reset_model();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed_part();
        random_windows(PHASE_ITEMS, 1'b0);
        drain_outputs();

        write_register(sws_pkg::CFG_TEMP_HIGH, 16'(800));
        write_register(sws_pkg::CFG_TEMP_LOW, 16'(-400));
        write_register(sws_pkg::CFG_HUMID_HIGH, 16'(1000));
        write_register(sws_pkg::CFG_ACCEL_LIM, 16'hFFFF);
        write_register(sws_pkg::CFG_GYRO_LIM, 16'hFFFF);
        write_register(sws_pkg::CFG_VIB_SHARE, 16'd0);
        write_register(sws_pkg::CFG_MOT_SHARE, 16'd256);
        random_windows(PHASE_ITEMS, 1'b0);
        drain_outputs();

        write_register(sws_pkg::CFG_TEMP_HIGH, 16'(-400));
        write_register(sws_pkg::CFG_TEMP_LOW, 16'(800));
        write_register(sws_pkg::CFG_HUMID_HIGH, 16'd0);
        write_register(sws_pkg::CFG_ACCEL_LIM, 16'd0);
        write_register(sws_pkg::CFG_GYRO_LIM, 16'd0);
        write_register(sws_pkg::CFG_VIB_SHARE, 16'd256);
        write_register(sws_pkg::CFG_MOT_SHARE, 16'h01FF);
        write_register(sws_pkg::CFG_UNUSED, 16'hFFFF);
        random_windows(sws_pkg::MAX_MOTION + 5 + PHASE_ITEMS, 1'b1);
        drain_outputs();

        write_register(sws_pkg::CFG_TEMP_HIGH, 16'($urandom));
        write_register(sws_pkg::CFG_TEMP_LOW, 16'($urandom));
        write_register(sws_pkg::CFG_HUMID_HIGH, 16'($urandom_range(300, 700)));
        write_register(sws_pkg::CFG_ACCEL_LIM, 16'($urandom_range(500, 40000)));
        write_register(sws_pkg::CFG_GYRO_LIM, 16'($urandom_range(500, 20000)));
        write_register(sws_pkg::CFG_VIB_SHARE, 16'($urandom_range(0, 300)));
        write_register(sws_pkg::CFG_MOT_SHARE, 16'($urandom));
        random_windows(PHASE_ITEMS, 1'b0);
        drain_outputs();

        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
